### src/char_lcd_command_sequencer_unit_macros.svh
// Assertion macros for the character LCD command sequencer checkers.
// Included by the port checker; holds no logic of its own.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CLCD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("clcd port check failed");

// Next-cycle implication, disabled while reset is asserted
`define CLCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("clcd port check failed");

`endif

### src/clcd_pkg.sv
// Shared types and constants of the character LCD command sequencer.
// Used by the front, queue and back modules; depends on nothing.
package clcd_pkg;

    // Request types carried in s_tuser
    localparam logic [3:0] REQ_CHAR      = 4'd0;
    localparam logic [3:0] REQ_RAW       = 4'd1;
    localparam logic [3:0] REQ_POSITION  = 4'd2;
    localparam logic [3:0] REQ_HOME      = 4'd3;
    localparam logic [3:0] REQ_CLEAR     = 4'd4;
    localparam logic [3:0] REQ_DISPLAY   = 4'd5;
    localparam logic [3:0] REQ_CURSOR    = 4'd6;
    localparam logic [3:0] REQ_BLINK     = 4'd7;
    localparam logic [3:0] REQ_GLYPH_ADR = 4'd8;
    localparam logic [3:0] REQ_GLYPH_ROW = 4'd9;
    localparam logic [3:0] REQ_INIT      = 4'd10;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NIBBLE_BUS   = 2'd2;

    // Settle codes
    localparam logic [1:0] SETTLE_NONE = 2'd0;
    localparam logic [1:0] SETTLE_2MS  = 2'd1;
    localparam logic [1:0] SETTLE_7MS  = 2'd2;
    localparam logic [1:0] SETTLE_35MS = 2'd3;

    // Controller commands
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_CONTROL    = 8'h08;
    localparam logic [7:0] CMD_SHIFT      = 8'h14;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'h20;
    localparam logic [7:0] CMD_FUNC_8BIT  = 8'h30;
    localparam logic [7:0] FUNC_TWO_LINE  = 8'h08;
    localparam logic [7:0] CMD_CGRAM_ADR  = 8'h40;
    localparam logic [7:0] CMD_DDRAM_ADR  = 8'h80;
    localparam logic [7:0] NIBBLE_WAKE    = 8'h03;
    localparam logic [7:0] NIBBLE_4BIT    = 8'h02;

    // Display control bits
    localparam logic [2:0] CTRL_DISPLAY = 3'b100;
    localparam logic [2:0] CTRL_CURSOR  = 3'b010;
    localparam logic [2:0] CTRL_BLINK   = 3'b001;

    // Geometry limits and reset values
    localparam logic [2:0] ROWS_MAX      = 3'd4;
    localparam logic [4:0] COLS_MAX      = 5'd20;
    localparam logic [2:0] ROWS_RESET    = 3'd2;
    localparam logic [4:0] COLS_RESET    = 5'd16;

    // Job kinds passed from front to back
    localparam logic [2:0] KIND_SINGLE = 3'd0;
    localparam logic [2:0] KIND_CHAR   = 3'd1;
    localparam logic [2:0] KIND_CLEAR  = 3'd2;
    localparam logic [2:0] KIND_INIT   = 3'd3;
    localparam logic [2:0] KIND_REJECT = 3'd4;

    // One classified request
    typedef struct packed {
        logic [2:0] kind;
        logic       rs;        // register select of the first byte
        logic [7:0] byte0;     // first byte, or first control command of init
        logic [1:0] settle0;   // settle code of the first byte
        logic [7:0] byte1;     // wrap address, or second control command of init
        logic       wrap;      // character request moves to the next row
        logic       nibble;    // 4-bit bus transfers
        logic       multirow;  // more than one row in use
    } clcd_job_t;

    // DDRAM start address of each row
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            2'd3:    base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

endpackage

### src/clcd_front.sv
// Front end: configuration registers, request intake, cursor tracking and
// classification of each request into one job. Depends on clcd_pkg.
module clcd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,
    input  logic [3:0]                      s_tuser,
    output logic                            job_push,
    output clcd_pkg::clcd_job_t             job_data,
    input  logic                            job_ready
);
    import clcd_pkg::*;

    logic [2:0] row_count_reg;
    logic [4:0] column_count_reg;
    logic       nibble_bus_reg;
    logic [4:0] cursor_column_reg, cursor_column_next;
    logic [1:0] cursor_row_reg, cursor_row_next;
    logic [2:0] ctrl_bits_reg, ctrl_bits_next;

    logic [7:0] byte_value;
    logic [4:0] target_column;
    logic [2:0] target_row;
    logic       switch_on;
    logic [2:0] glyph_slot;

    logic [4:0] eff_cols;
    logic [2:0] eff_rows;
    logic       accept;
    logic       job_ok;
    logic [4:0] col_inc;
    logic       col_wrap;
    logic [1:0] row_inc;
    logic [1:0] row_wrapped;
    logic       pos_reject;
    logic [2:0] ctrl_bit;
    logic [2:0] ctrl_set;
    logic [2:0] init_ctrl1;
    logic [2:0] init_ctrl2;

    // Unpack the request
    assign byte_value    = s_tdata[7:0];
    assign target_column = s_tdata[12:8];
    assign target_row    = s_tdata[15:13];
    assign switch_on     = s_tdata[16];
    assign glyph_slot    = s_tdata[19:17];

    // Clamp geometry to the supported range
    assign eff_cols = (column_count_reg == 5'd0) ? 5'd1 :
                      (column_count_reg > COLS_MAX) ? COLS_MAX : column_count_reg;
    assign eff_rows = (row_count_reg == 3'd0) ? 3'd1 :
                      (row_count_reg > ROWS_MAX) ? ROWS_MAX : row_count_reg;

    assign s_tready = job_ready;
    assign accept   = s_tvalid && s_tready;
    assign job_push = accept && job_ok;

    // Cursor advance with row wrap
    assign col_inc     = cursor_column_reg + 5'd1;
    assign col_wrap    = (col_inc >= eff_cols);
    assign row_inc     = cursor_row_reg + 2'd1;
    assign row_wrapped = ({1'b0, row_inc} >= eff_rows) ? 2'd0 : row_inc;

    assign pos_reject = (target_column >= eff_cols) || (target_row >= eff_rows);

    // Control bit touched by display, cursor or blink requests
    always_comb begin
        case (s_tuser)
            REQ_DISPLAY: ctrl_bit = CTRL_DISPLAY;
            REQ_CURSOR:  ctrl_bit = CTRL_CURSOR;
            REQ_BLINK:   ctrl_bit = CTRL_BLINK;
            default:     ctrl_bit = 3'b000;
        endcase
    end
    assign ctrl_set   = switch_on ? (ctrl_bits_reg | ctrl_bit) : (ctrl_bits_reg & ~ctrl_bit);
    assign init_ctrl1 = ctrl_bits_reg | CTRL_DISPLAY;
    assign init_ctrl2 = init_ctrl1 & ~CTRL_CURSOR;

    // Classify the request and work out the cursor it leaves
    always_comb begin
        job_ok             = 1'b1;
        job_data.kind      = KIND_SINGLE;
        job_data.rs        = 1'b0;
        job_data.byte0     = 8'h00;
        job_data.settle0   = SETTLE_2MS;
        job_data.byte1     = 8'h00;
        job_data.wrap      = 1'b0;
        job_data.nibble    = nibble_bus_reg;
        job_data.multirow  = (eff_rows > 3'd1);
        cursor_column_next = cursor_column_reg;
        cursor_row_next    = cursor_row_reg;
        ctrl_bits_next     = ctrl_bits_reg;
        case (s_tuser)
            REQ_CHAR: begin
                job_data.kind    = KIND_CHAR;
                job_data.rs      = 1'b1;
                job_data.byte0   = byte_value;
                job_data.settle0 = SETTLE_NONE;
                job_data.wrap    = col_wrap;
                job_data.byte1   = CMD_DDRAM_ADR | row_base(row_wrapped);
                if (col_wrap) begin
                    cursor_column_next = 5'd0;
                    cursor_row_next    = row_wrapped;
                end else begin
                    cursor_column_next = col_inc;
                end
            end
            REQ_RAW: begin
                job_data.byte0 = byte_value;
            end
            REQ_POSITION: begin
                if (pos_reject) begin
                    job_data.kind = KIND_REJECT;
                end else begin
                    job_data.byte0 = CMD_DDRAM_ADR |
                                     (row_base(target_row[1:0]) + {3'b000, target_column});
                    cursor_column_next = target_column;
                    cursor_row_next    = target_row[1:0];
                end
            end
            REQ_HOME: begin
                job_data.byte0     = CMD_HOME;
                job_data.settle0   = SETTLE_7MS;
                cursor_column_next = 5'd0;
                cursor_row_next    = 2'd0;
            end
            REQ_CLEAR: begin
                job_data.kind      = KIND_CLEAR;
                cursor_column_next = 5'd0;
                cursor_row_next    = 2'd0;
            end
            REQ_DISPLAY, REQ_CURSOR, REQ_BLINK: begin
                job_data.byte0 = CMD_CONTROL | {5'b00000, ctrl_set};
                ctrl_bits_next = ctrl_set;
            end
            REQ_GLYPH_ADR: begin
                job_data.byte0 = CMD_CGRAM_ADR | {2'b00, glyph_slot, 3'b000};
            end
            REQ_GLYPH_ROW: begin
                job_data.rs      = 1'b1;
                job_data.byte0   = byte_value;
                job_data.settle0 = SETTLE_NONE;
            end
            REQ_INIT: begin
                job_data.kind      = KIND_INIT;
                job_data.byte0     = CMD_CONTROL | {5'b00000, init_ctrl1};
                job_data.byte1     = CMD_CONTROL | {5'b00000, init_ctrl2};
                ctrl_bits_next     = CTRL_DISPLAY;
                cursor_column_next = 5'd0;
                cursor_row_next    = 2'd0;
            end
            default: begin
                job_ok = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= ROWS_RESET;
            column_count_reg <= COLS_RESET;
            nibble_bus_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_wr_data[2:0];
                REG_COLUMN_COUNT: column_count_reg <= cfg_wr_data[4:0];
                REG_NIBBLE_BUS:   nibble_bus_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Cursor and control bits advance on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_column_reg <= 5'd0;
            cursor_row_reg    <= 2'd0;
            ctrl_bits_reg     <= 3'b000;
        end else if (accept) begin
            cursor_column_reg <= cursor_column_next;
            cursor_row_reg    <= cursor_row_next;
            ctrl_bits_reg     <= ctrl_bits_next;
        end
    end

endmodule

### src/clcd_queue.sv
// Short job queue between the front and the back end.
// Register-array FIFO of clcd_job_t entries; depends on clcd_pkg.
module clcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  clcd_pkg::clcd_job_t push_data,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output clcd_pkg::clcd_job_t pop_data
);
    import clcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    clcd_job_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/clcd_back.sv
// Back end: steps through the bytes of one job, splits bytes into nibbles
// on a 4-bit bus and holds each transfer in an output register. Uses clcd_pkg.
module clcd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  clcd_pkg::clcd_job_t job_data,
    output logic                job_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import clcd_pkg::*;

    // Init sequence steps
    localparam logic [3:0] INIT_WAKE0  = 4'd0;
    localparam logic [3:0] INIT_WAKE1  = 4'd1;
    localparam logic [3:0] INIT_WAKE2  = 4'd2;
    localparam logic [3:0] INIT_WAKE3  = 4'd3;
    localparam logic [3:0] INIT_FUNC   = 4'd4;
    localparam logic [3:0] INIT_CTRL1  = 4'd5;
    localparam logic [3:0] INIT_CTRL2  = 4'd6;
    localparam logic [3:0] INIT_CTRL3  = 4'd7;
    localparam logic [3:0] INIT_CLEAR  = 4'd8;
    localparam logic [3:0] INIT_HOME   = 4'd9;
    localparam logic [3:0] INIT_ENTRY  = 4'd10;
    localparam logic [3:0] INIT_SHIFT  = 4'd11;
    localparam logic [3:0] STEP_FIRST  = 4'd0;
    localparam logic [3:0] STEP_SECOND = 4'd1;

    clcd_job_t  job_reg;
    logic       job_valid_reg;
    logic [3:0] step_reg;
    logic       half_reg;

    logic       out_valid_reg;
    logic       out_rs_reg;
    logic [7:0] out_bus_reg;
    logic       out_strobe_reg;
    logic [1:0] out_settle_reg;
    logic       out_status_reg;
    logic       out_last_reg;

    logic       out_free;
    logic       advance;
    logic       cur_rs;
    logic [7:0] cur_byte;
    logic [1:0] cur_settle;
    logic       cur_single;
    logic       cur_reject;
    logic [3:0] last_step;
    logic [3:0] step_next;
    logic       two_nibbles;
    logic       step_done;
    logic       xfer_last;
    logic [7:0] xfer_value;
    logic [1:0] xfer_settle;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = job_valid_reg && out_free;

    // Byte of the current step
    always_comb begin
        cur_rs     = 1'b0;
        cur_byte   = job_reg.byte0;
        cur_settle = job_reg.settle0;
        cur_single = 1'b0;
        cur_reject = 1'b0;
        last_step  = STEP_FIRST;
        case (job_reg.kind)
            KIND_SINGLE: begin
                cur_rs = job_reg.rs;
            end
            KIND_CHAR: begin
                last_step = job_reg.wrap ? STEP_SECOND : STEP_FIRST;
                if (step_reg == STEP_FIRST) begin
                    cur_rs = job_reg.rs;
                end else begin
                    cur_byte   = job_reg.byte1;
                    cur_settle = SETTLE_2MS;
                end
            end
            KIND_CLEAR: begin
                last_step = STEP_SECOND;
                if (step_reg == STEP_FIRST) begin
                    cur_byte   = CMD_CLEAR;
                    cur_settle = SETTLE_2MS;
                end else begin
                    cur_byte   = CMD_HOME;
                    cur_settle = SETTLE_7MS;
                end
            end
            KIND_INIT: begin
                last_step  = INIT_SHIFT;
                cur_settle = SETTLE_2MS;
                case (step_reg)
                    INIT_WAKE0, INIT_WAKE1, INIT_WAKE2: begin
                        cur_byte   = job_reg.nibble ? NIBBLE_WAKE : CMD_FUNC_8BIT;
                        cur_settle = SETTLE_35MS;
                        cur_single = 1'b1;
                    end
                    INIT_WAKE3: begin
                        cur_byte   = NIBBLE_4BIT;
                        cur_settle = SETTLE_35MS;
                        cur_single = 1'b1;
                    end
                    INIT_FUNC: begin
                        cur_byte   = (job_reg.nibble ? CMD_FUNC_4BIT : CMD_FUNC_8BIT)
                                     | FUNC_TWO_LINE;
                        cur_settle = SETTLE_35MS;
                    end
                    INIT_CTRL1: cur_byte = job_reg.byte0;
                    INIT_CTRL2: cur_byte = job_reg.byte1;
                    INIT_CTRL3: cur_byte = CMD_CONTROL | {5'b00000, CTRL_DISPLAY};
                    INIT_CLEAR: cur_byte = CMD_CLEAR;
                    INIT_HOME: begin
                        cur_byte   = CMD_HOME;
                        cur_settle = SETTLE_7MS;
                    end
                    INIT_ENTRY: cur_byte = CMD_ENTRY_MODE;
                    INIT_SHIFT: cur_byte = CMD_SHIFT;
                    default:    cur_byte = CMD_SHIFT;
                endcase
            end
            KIND_REJECT: begin
                cur_byte   = 8'h00;
                cur_settle = SETTLE_NONE;
                cur_single = 1'b1;
                cur_reject = 1'b1;
            end
            default: begin
                cur_single = 1'b1;
            end
        endcase
    end

    // Next step, skipping the fourth wake nibble on an 8-bit bus and the
    // function set on a one-row display
    always_comb begin
        step_next = step_reg + 4'd1;
        if (job_reg.kind == KIND_INIT) begin
            if (step_next == INIT_WAKE3 && !job_reg.nibble) begin
                step_next = INIT_FUNC;
            end
            if (step_next == INIT_FUNC && !job_reg.multirow) begin
                step_next = INIT_CTRL1;
            end
        end
    end

    // Split into nibbles, high first; only the low nibble waits
    assign two_nibbles = job_reg.nibble && !cur_single;
    assign step_done   = !two_nibbles || half_reg;
    assign xfer_last   = step_done && (step_reg == last_step);
    assign xfer_value  = !two_nibbles ? cur_byte :
                         half_reg ? {4'h0, cur_byte[3:0]} : {4'h0, cur_byte[7:4]};
    assign xfer_settle = (two_nibbles && !half_reg) ? SETTLE_NONE : cur_settle;

    assign job_pop = job_valid && (!job_valid_reg || (advance && xfer_last));

    // Load the next job or advance through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            step_reg      <= STEP_FIRST;
            half_reg      <= 1'b0;
        end else if (job_pop) begin
            job_valid_reg <= 1'b1;
            step_reg      <= STEP_FIRST;
            half_reg      <= 1'b0;
        end else if (advance) begin
            if (xfer_last) begin
                job_valid_reg <= 1'b0;
            end else if (step_done) begin
                step_reg <= step_next;
                half_reg <= 1'b0;
            end else begin
                half_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job_data;
        end
    end

    // Output register: hold while stalled, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rs_reg     <= cur_rs;
            out_bus_reg    <= xfer_value;
            out_strobe_reg <= !cur_reject;
            out_settle_reg <= xfer_settle;
            out_status_reg <= cur_reject;
            out_last_reg   <= xfer_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'h0, out_status_reg, out_settle_reg, out_strobe_reg, out_bus_reg};

endmodule

### src/char_lcd_command_sequencer_unit.sv
// Top level of the character LCD command sequencer.
// Instantiates clcd_front, clcd_queue and clcd_back; uses clcd_pkg.
//
//  Channel  Direction  Accept when          Carries
//  s_       in         s_tvalid & s_tready  one display request
//  m_       out        m_tvalid & m_tready  one strobe transfer to the display
//  cfg_     in         cfg_wr_en            row count, column count, bus width
//
// The front accepts one request per cycle while the job queue has room.
// The back sequencer emits one transfer per cycle while m_tready is high, and a
// request takes 1 to 20 transfers (up to 20 for init on a 4-bit bus).
// Reset clears the cursor, the control bits, the queue and the output
// register and loads the default geometry (2 rows, 16 columns, 8-bit bus).
// m_tready low holds the output transfer; a full queue drops s_tready.
module char_lcd_command_sequencer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // byte_value[7:0], target_column[12:8], target_row[15:13],
    // switch_on[16], glyph_slot[19:17], zero[23:20]
    input  logic [23:0]                      s_tdata,
    // req_type[3:0]
    input  logic [3:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // bus_value[7:0], strobe_valid[8], settle_code[10:9], status[11], zero[15:12]
    output logic [15:0]                      m_tdata,
    // register_select[0]
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import clcd_pkg::*;

    logic      job_push;
    clcd_job_t job_in;
    logic      job_ready;
    logic      job_pop;
    logic      job_valid;
    clcd_job_t job_out;

    // Classify requests
    clcd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .job_push     (job_push),
        .job_data     (job_in),
        .job_ready    (job_ready)
    );

    // Decouple front and back
    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_data  (job_in),
        .push_ready (job_ready),
        .pop        (job_pop),
        .pop_valid  (job_valid),
        .pop_data   (job_out)
    );

    // Expand jobs into bus transfers
    clcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### src/clcd_port_checker.sv
// Port-level checks of the character LCD command sequencer output channel.
// Uses char_lcd_command_sequencer_unit_macros.svh; bound to the top level.
`include "char_lcd_command_sequencer_unit_macros.svh"

module clcd_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic        m_stalled;
    logic [17:0] m_payload;

    assign m_stalled = m_tvalid && !m_tready;
    assign m_payload = {m_tlast, m_tuser, m_tdata};

    // A stalled transfer holds its payload
    `CLCD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_stalled, m_tvalid && $stable(m_payload))

    // A rejected position is a lone, empty result
    `CLCD_ASSERT_IMPLY(a_reject_empty, aclk, aresetn, m_tvalid && m_tdata[11], m_tlast && !m_tuser && (m_tdata[10:0] == 11'd0))

    // Every result without a strobe is a rejection
    `CLCD_ASSERT_IMPLY(a_strobe_or_reject, aclk, aresetn, m_tvalid && !m_tdata[8], m_tdata[11])

    // Data writes never carry the long settle waits
    `CLCD_ASSERT_IMPLY(a_data_settle, aclk, aresetn, m_tvalid && m_tuser, !m_tdata[10])

endmodule

bind char_lcd_command_sequencer_unit clcd_port_checker u_clcd_port_checker (.*);
